>>> rtl/core/rrdo_pkg.sv
// Shared types, codes and constants of the record ring with oldest-record drop.
package rrdo_pkg;

  localparam int DEPTH_LOG2_DEF = 6;
  localparam int HEADER_BYTES   = 2;
  localparam logic [4:0] DROP_MAX = 5'd31;

  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TOO_LONG = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_TOO_SMALL = 3'd3;
  localparam logic [2:0] ST_BUSY     = 3'd4;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
    logic [5:0] record_length;
    logic [7:0] capacity;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] read_byte;
    logic       has_byte;
    logic       last;
    logic [5:0] found_length;
    logic [4:0] dropped_count;
  } result_t;

  typedef enum logic [1:0] {
    K_BEGIN,
    K_APPEND,
    K_READ
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [5:0] record_length;
    logic [7:0] capacity;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DROP_CHECK,
    S_DROP_HI,
    S_DROP_LO,
    S_HDR_LO,
    S_RD_HI,
    S_RD_LO,
    S_RD_BYTE
  } state_t;

endpackage

>>> rtl/core/rrdo_front.sv
// Front end: accept transactions, classify them, queue commands for the back end.
module rrdo_front
  import rrdo_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  item_t     item,
  output logic      busy,
  output cmd_head_t head,
  input  logic      pop
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       cmd_in;

  assign busy = (count == 2'd2);

  always_comb begin
    cmd_in.data_byte     = item.data_byte;
    cmd_in.record_length = item.record_length;
    cmd_in.capacity      = item.capacity;
    push                 = start && !busy;
    unique case (item.op)
      OP_BEGIN:  cmd_in.kind = K_BEGIN;
      OP_APPEND: cmd_in.kind = K_APPEND;
      OP_READ:   cmd_in.kind = K_READ;
      default: begin
        // unused code: drop it
        cmd_in.kind = K_READ;
        push        = 1'b0;
      end
    endcase
  end

  assign head.valid = (count != 2'd0);
  assign head.cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0) else $error("pop from empty command queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("push into full command queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("command queue count out of range");

endmodule

>>> rtl/core/rrdo_back.sv
// Back end: ring memory, pointers and the sequencer that executes commands.
module rrdo_back
  import rrdo_pkg::*;
#(
  parameter int DEPTH_LOG2 = DEPTH_LOG2_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_head_t head,
  output logic      pop,
  output result_t   result,
  output logic      strobe
);

  localparam int DW = DEPTH_LOG2;
  localparam int RING_SIZE = 1 << DW;
  localparam logic [7:0] SPACE = 8'(RING_SIZE - 1);

  logic [7:0] ring [RING_SIZE];
  logic [7:0] mem_q;
  logic [DW-1:0] rd_addr;
  logic          we;
  logic [DW-1:0] wa;
  logic [7:0]    wd;

  state_t state, state_next;
  cmd_t   cur, cur_next;
  logic [DW-1:0] rp, rp_next, wp, wp_next, pos, pos_next;
  logic          write_open, write_open_next;
  logic [5:0]    bytes_remaining, bytes_remaining_next;
  logic [4:0]    drops, drops_next;
  logic [7:0]    hi, hi_next;
  logic [5:0]    len, len_next;
  logic [5:0]    cnt, cnt_next;
  result_t       res_next;
  logic          strobe_next;

  logic [DW-1:0] used;
  logic [7:0]    need_used;
  logic          must_drop;
  logic [15:0]   len16;
  logic [16:0]   adv17;
  logic [DW-1:0] adv;
  logic [5:0]    len_clamped;
  logic          byte_last;

  always_comb begin
    used      = wp - rp;
    need_used = 8'(cur.record_length) + 8'(HEADER_BYTES) + 8'(used);
    must_drop = (need_used > SPACE) && (used != '0);
    len16     = {hi, mem_q};
    adv17     = 17'(len16) + 17'(HEADER_BYTES);
    adv       = (adv17 > 17'(used)) ? used : adv17[DW-1:0];
    if (used < DW'(HEADER_BYTES)) begin
      len_clamped = 6'd0;
    end else if (len16 > 16'(used - DW'(HEADER_BYTES))) begin
      len_clamped = 6'(used - DW'(HEADER_BYTES));
    end else begin
      len_clamped = len16[5:0];
    end
    byte_last = (cnt == len - 6'd1);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (head.valid && head.cmd.kind == K_BEGIN && !write_open &&
            (8'(head.cmd.record_length) + 8'(HEADER_BYTES) <= SPACE)) begin
          state_next = S_DROP_CHECK;
        end else if (head.valid && head.cmd.kind == K_READ && !write_open &&
                     used != '0) begin
          state_next = S_RD_HI;
        end
      end
      S_DROP_CHECK: state_next = must_drop ? S_DROP_HI : S_HDR_LO;
      S_DROP_HI:    state_next = S_DROP_LO;
      S_DROP_LO:    state_next = S_DROP_CHECK;
      S_HDR_LO:     state_next = S_IDLE;
      S_RD_HI:      state_next = S_RD_LO;
      S_RD_LO: begin
        if ((8'(cur.capacity) < 8'(len_clamped)) || len_clamped == 6'd0) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_RD_BYTE;
        end
      end
      S_RD_BYTE:    state_next = byte_last ? S_IDLE : S_RD_BYTE;
      default:      state_next = S_IDLE;
    endcase
  end

  // memory control and queue pop
  always_comb begin
    pop     = (state == S_IDLE) && head.valid;
    rd_addr = rp;
    we      = 1'b0;
    wa      = wp;
    wd      = 8'd0;
    unique case (state)
      S_DROP_CHECK: begin
        if (!must_drop) begin
          we = 1'b1;
          wa = wp;
          wd = 8'd0;
        end
      end
      S_DROP_HI, S_RD_HI: rd_addr = rp + DW'(1);
      S_HDR_LO: begin
        we = 1'b1;
        wa = wp + DW'(1);
        wd = 8'(cur.record_length);
      end
      S_RD_LO:   rd_addr = rp + DW'(HEADER_BYTES);
      S_RD_BYTE: rd_addr = pos + DW'(1);
      S_IDLE: begin
        if (head.valid && head.cmd.kind == K_APPEND && write_open) begin
          we = 1'b1;
          wa = wp;
          wd = head.cmd.data_byte;
        end
      end
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    cur_next             = cur;
    rp_next              = rp;
    wp_next              = wp;
    pos_next             = pos;
    write_open_next      = write_open;
    bytes_remaining_next = bytes_remaining;
    drops_next           = drops;
    hi_next              = hi;
    len_next             = len;
    cnt_next             = cnt;
    res_next             = '0;
    res_next.last        = 1'b1;
    strobe_next          = 1'b0;
    unique case (state)
      S_IDLE: begin
        cur_next   = head.cmd;
        drops_next = 5'd0;
        if (head.valid) begin
          unique case (head.cmd.kind)
            K_BEGIN: begin
              if (write_open) begin
                strobe_next     = 1'b1;
                res_next.status = ST_BUSY;
              end else if (8'(head.cmd.record_length) + 8'(HEADER_BYTES) > SPACE) begin
                strobe_next     = 1'b1;
                res_next.status = ST_TOO_LONG;
              end
            end
            K_APPEND: begin
              if (write_open) begin
                wp_next              = wp + DW'(1);
                bytes_remaining_next = bytes_remaining - 6'd1;
                if (bytes_remaining == 6'd1) write_open_next = 1'b0;
              end
            end
            K_READ: begin
              if (write_open) begin
                strobe_next     = 1'b1;
                res_next.status = ST_BUSY;
              end else if (used == '0) begin
                strobe_next     = 1'b1;
                res_next.status = ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      S_DROP_HI: hi_next = mem_q;
      S_DROP_LO: begin
        rp_next = rp + adv;
        if (drops != DROP_MAX) drops_next = drops + 5'd1;
      end
      S_HDR_LO: begin
        wp_next                = wp + DW'(HEADER_BYTES);
        bytes_remaining_next   = cur.record_length;
        write_open_next        = (cur.record_length != 6'd0);
        strobe_next            = 1'b1;
        res_next.status        = ST_OK;
        res_next.dropped_count = drops;
      end
      S_RD_HI: hi_next = mem_q;
      S_RD_LO: begin
        len_next = len_clamped;
        pos_next = rp + DW'(HEADER_BYTES);
        cnt_next = 6'd0;
        if (8'(cur.capacity) < 8'(len_clamped)) begin
          strobe_next           = 1'b1;
          res_next.status       = ST_TOO_SMALL;
          res_next.found_length = len_clamped;
        end else if (len_clamped == 6'd0) begin
          strobe_next     = 1'b1;
          res_next.status = ST_OK;
          rp_next = rp + ((used < DW'(HEADER_BYTES)) ? used : DW'(HEADER_BYTES));
        end
      end
      S_RD_BYTE: begin
        strobe_next           = 1'b1;
        res_next.status       = ST_OK;
        res_next.read_byte    = mem_q;
        res_next.has_byte     = 1'b1;
        res_next.last         = byte_last;
        res_next.found_length = len;
        pos_next              = pos + DW'(1);
        cnt_next              = cnt + 6'd1;
        if (byte_last) rp_next = pos + DW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) ring[wa] <= wd;
    mem_q <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    cur    <= cur_next;
    pos    <= pos_next;
    hi     <= hi_next;
    len    <= len_next;
    cnt    <= cnt_next;
    drops  <= drops_next;
    result <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      rp              <= '0;
      wp              <= '0;
      write_open      <= 1'b0;
      bytes_remaining <= 6'd0;
      strobe          <= 1'b0;
    end else begin
      state           <= state_next;
      rp              <= rp_next;
      wp              <= wp_next;
      write_open      <= write_open_next;
      bytes_remaining <= bytes_remaining_next;
      strobe          <= strobe_next;
    end
  end

  a_open_has_bytes: assert property (@(posedge clk) disable iff (rst)
    write_open |-> bytes_remaining != 6'd0) else $error("open write with no bytes left");
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    strobe && result.has_byte |-> result.status == ST_OK)
    else $error("data byte with non-ok status");
  a_drops_on_begin: assert property (@(posedge clk) disable iff (rst)
    strobe && result.dropped_count != 5'd0 |-> !result.has_byte && result.last)
    else $error("drop count on a read result");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !pop) else $error("command taken while sequencer busy");

endmodule

>>> rtl/core/record_ring_drop_oldest.sv
// Top level of the byte ring of length-prefixed records that drops the oldest.
//
// Records live in a byte ring of 2^DEPTH_LOG2 entries, each as a 2-byte
// big-endian length header and its data; one slot stays free. A transaction
// is taken at a clock edge with start high and busy low; busy rises only
// when the two-entry command queue is full. Results leave through a
// registered port, one per cycle marked by strobe, and the receiver cannot
// stall them: be ready every cycle. Once a transaction reaches the sequencer:
// an append gives no result; a begin write or read answered busy, too long or
// empty is answered from the idle state; an accepted begin write drops the
// oldest records one by one until the new one fits, then writes its header
// and answers; a read that reaches the ring fetches the header, then gives a
// too-small or zero-length answer or else streams the record bytes back to
// back. The ring memory has a single read port with a registered output.
// Results are registered and appear in the cycle after the sequencer makes
// them. The ring needs no clearing after reset.
module record_ring_drop_oldest
  import rrdo_pkg::*;
#(
  parameter int DEPTH_LOG2 = DEPTH_LOG2_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output result_t result,
  output logic    strobe
);

  cmd_head_t head;
  logic      pop;

  // accept and classify; drop unused op codes
  rrdo_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .head  (head),
    .pop   (pop)
  );

  // execute commands against the ring
  rrdo_back #(
    .DEPTH_LOG2 (DEPTH_LOG2)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result),
    .strobe (strobe)
  );

endmodule

>>> bench/tb_record_ring_drop_oldest.sv
// Testbench for the record ring that drops its oldest records to make room.
`timescale 1ns / 100ps

module tb_record_ring_drop_oldest;
  import rrdo_pkg::*;

  localparam int RING_ENTRIES = 64;
  localparam int RING_USABLE  = RING_ENTRIES - 1;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  result_t result;
  logic    strobe;

  record_ring_drop_oldest dut (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .result(result), .strobe(strobe)
  );

  always #4 clk = ~clk;

  // Predictor state: our own copy of the ring and its pointers.
  logic [7:0] ring_mem [RING_ENTRIES];
  logic [5:0] rd_ptr, wr_ptr, bytes_left;
  logic       write_busy;

  item_t   pending_items [$];
  result_t expected_results [$];
  int      error_count = 0;
  bit      stimulus_done = 0;

  function automatic int used_count();
    return int'(6'(wr_ptr - rd_ptr));
  endfunction

  function automatic int header_len();
    return {ring_mem[rd_ptr], ring_mem[6'(rd_ptr + 1)]};
  endfunction

  function automatic result_t make_result(logic [2:0] st, logic [7:0] b, logic h,
                                          logic l, logic [5:0] fl, logic [4:0] dc);
    result_t r;
    r.status = st; r.read_byte = b; r.has_byte = h;
    r.last = l; r.found_length = fl; r.dropped_count = dc;
    return r;
  endfunction

  // Advance the predictor by one accepted transaction and queue its results.
  task automatic predict_transaction(item_t it);
    int need, drops, adv, used, len;
    logic [5:0] pos;
    case (it.op)
      OP_BEGIN: begin
        need = it.record_length + HEADER_BYTES;
        drops = 0;
        if (write_busy) begin
          expected_results.push_back(make_result(ST_BUSY, 0, 0, 1, 0, 0));
        end else if (need > RING_USABLE) begin
          expected_results.push_back(make_result(ST_TOO_LONG, 0, 0, 1, 0, 0));
        end else begin
          // Drop oldest records until the new one fits.
          while (need + used_count() > RING_USABLE && used_count() != 0) begin
            adv = header_len() + HEADER_BYTES;
            if (adv > used_count()) adv = used_count();
            rd_ptr = 6'(rd_ptr + adv);
            if (drops < DROP_MAX) drops++;
          end
          ring_mem[wr_ptr] = 8'h00;
          ring_mem[6'(wr_ptr + 1)] = {2'b00, it.record_length};
          wr_ptr = 6'(wr_ptr + HEADER_BYTES);
          bytes_left = it.record_length;
          write_busy = (it.record_length != 0);
          expected_results.push_back(make_result(ST_OK, 0, 0, 1, 0, 5'(drops)));
        end
      end
      OP_APPEND: begin
        if (write_busy) begin
          ring_mem[wr_ptr] = it.data_byte;
          wr_ptr = 6'(wr_ptr + 1);
          bytes_left = 6'(bytes_left - 1);
          if (bytes_left == 0) write_busy = 0;
        end
      end
      OP_READ: begin
        used = used_count();
        if (write_busy) begin
          expected_results.push_back(make_result(ST_BUSY, 0, 0, 1, 0, 0));
        end else if (used == 0) begin
          expected_results.push_back(make_result(ST_EMPTY, 0, 0, 1, 0, 0));
        end else begin
          len = header_len();
          if (used < HEADER_BYTES) len = 0;
          else if (len > used - HEADER_BYTES) len = used - HEADER_BYTES;
          if (it.capacity < len) begin
            // Too small: report the length and leave the record in place.
            expected_results.push_back(make_result(ST_TOO_SMALL, 0, 0, 1, 6'(len), 0));
          end else if (len == 0) begin
            rd_ptr = 6'(rd_ptr + ((used < HEADER_BYTES) ? used : HEADER_BYTES));
            expected_results.push_back(make_result(ST_OK, 0, 0, 1, 0, 0));
          end else begin
            pos = 6'(rd_ptr + HEADER_BYTES);
            for (int i = 0; i < len; i++) begin
              expected_results.push_back(make_result(ST_OK, ring_mem[pos], 1,
                                                     (i + 1 == len), 6'(len), 0));
              pos = 6'(pos + 1);
            end
            rd_ptr = pos;
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic item_t make_item(logic [1:0] op, logic [7:0] db,
                                      logic [5:0] len, logic [7:0] cap);
    item_t it;
    it.op = op; it.data_byte = db; it.record_length = len; it.capacity = cap;
    return it;
  endfunction

  // Queue a complete record: begin, then exactly its data bytes.
  task automatic add_record(int len);
    pending_items.push_back(make_item(OP_BEGIN, 8'($urandom), 6'(len), 8'($urandom)));
    for (int i = 0; i < len; i++)
      pending_items.push_back(make_item(OP_APPEND, 8'($urandom), 6'($urandom),
                                        8'($urandom)));
  endtask

  task automatic add_read(logic [7:0] cap);
    pending_items.push_back(make_item(OP_READ, 8'($urandom), 6'($urandom), cap));
  endtask

  // Busy as seen at the last rising edge.
  logic busy_at_edge = 1'b0;

  // Driver: present items at falling edges, in bursts with random gaps.
  int gap_left = 0;
  int burst_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy_at_edge) begin
        // Previous transaction was taken at the rising edge.
      end
      if (start && busy_at_edge) begin
        // Hold the item until the block takes it.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_items.size() > 0) begin
        item <= pending_items.pop_front();
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Track acceptance at rising edges and feed accepted items to the predictor.
  always @(posedge clk) begin
    busy_at_edge <= busy;
    if (!rst && start && !busy) predict_transaction(item);
  end

  // Monitor: every strobed result must match the oldest expectation.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && strobe) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d byte %0h", result.status, result.read_byte);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result.status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, result.status);
          error_count++;
        end
        if (result.read_byte !== exp_r.read_byte) begin
          $error("read_byte: expected %0h, actual %0h", exp_r.read_byte, result.read_byte);
          error_count++;
        end
        if (result.has_byte !== exp_r.has_byte) begin
          $error("has_byte: expected %0d, actual %0d", exp_r.has_byte, result.has_byte);
          error_count++;
        end
        if (result.last !== exp_r.last) begin
          $error("last: expected %0d, actual %0d", exp_r.last, result.last);
          error_count++;
        end
        if (result.found_length !== exp_r.found_length) begin
          $error("found_length: expected %0d, actual %0d",
                 exp_r.found_length, result.found_length);
          error_count++;
        end
        if (result.dropped_count !== exp_r.dropped_count) begin
          $error("dropped_count: expected %0d, actual %0d",
                 exp_r.dropped_count, result.dropped_count);
          error_count++;
        end
      end
    end
  end

  initial begin
    int r;
    rd_ptr = 0; wr_ptr = 0; bytes_left = 0; write_busy = 0;
    for (int i = 0; i < RING_ENTRIES; i++) ring_mem[i] = 8'h00;

    // Directed: empty read, zero-length record, busy cases, too long, extremes.
    add_read(8'hFF);
    add_record(0);
    add_read(8'h00);
    pending_items.push_back(make_item(OP_APPEND, 8'hFF, 6'h3F, 8'hFF)); // ignored
    pending_items.push_back(make_item(2'd3, 8'hAA, 6'h15, 8'h55));       // unused op
    pending_items.push_back(make_item(OP_BEGIN, 8'h00, 6'd62, 8'h00));  // too long
    pending_items.push_back(make_item(OP_BEGIN, 8'h00, 6'd63, 8'h00));  // too long
    pending_items.push_back(make_item(OP_BEGIN, 8'h00, 6'd3, 8'h00));
    pending_items.push_back(make_item(OP_APPEND, 8'h00, 6'd0, 8'h00));
    pending_items.push_back(make_item(OP_READ, 8'h00, 6'd0, 8'hFF));    // busy
    pending_items.push_back(make_item(OP_BEGIN, 8'h00, 6'd1, 8'h00));   // busy
    pending_items.push_back(make_item(OP_APPEND, 8'hFF, 6'd0, 8'h00));
    pending_items.push_back(make_item(OP_APPEND, 8'h5A, 6'd0, 8'h00));
    add_read(8'd2);                                                     // too small
    add_read(8'd3);
    add_record(61);                                                     // largest fits
    add_record(1);                                                      // drops it
    add_read(8'hFF);

    // Random: mostly well-formed records with reads; some noise.
    while (pending_items.size() < 200) begin
      r = $urandom_range(0, 9);
      if (r < 5) add_record(($urandom_range(0, 3) == 0) ? $urandom_range(0, 61)
                                                       : $urandom_range(0, 12));
      else if (r < 8) add_read(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 8))
                                                           : 8'($urandom));
      else pending_items.push_back(make_item(2'($urandom), 8'($urandom), 6'($urandom),
                                             8'($urandom)));
    end

    repeat (2) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    wait (pending_items.size() == 0);
    @(posedge clk);
    while (start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> files.f
rtl/core/rrdo_pkg.sv
rtl/core/rrdo_front.sv
rtl/core/rrdo_back.sv
rtl/core/record_ring_drop_oldest.sv
bench/tb_record_ring_drop_oldest.sv
